// File: rtl/cesd_pkg.sv
// Shared types, character codes and escape table for the C escape decoder.
package cesd_pkg;

  // Decoder modes, one-hot.
  typedef enum logic [4:0] {
    MODE_TEXT     = 5'b00001,
    MODE_ESC      = 5'b00010,
    MODE_HEXSTART = 5'b00100,
    MODE_HEX      = 5'b01000,
    MODE_OCT      = 5'b10000
  } mode_t;

  // One queued result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } result_t;

  localparam int unsigned RESULT_DEPTH = 4;
  localparam int unsigned PTR_W        = $clog2(RESULT_DEPTH);
  localparam int unsigned CNT_W        = $clog2(RESULT_DEPTH + 1);

  localparam logic [1:0] OCT_LAST_DIGIT = 2'd2;  // digits taken before the third one

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  // Single-letter escapes; anything else maps to itself.
  function automatic logic [7:0] escape_code(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h61:   r = 8'h07;  // a
      8'h62:   r = 8'h08;  // b
      8'h66:   r = 8'h0C;  // f
      8'h6E:   r = 8'h0A;  // n
      8'h72:   r = 8'h0D;  // r
      8'h74:   r = 8'h09;  // t
      8'h76:   r = 8'h0B;  // v
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/c_escape_sequence_decoder.sv
// C escape decoder: one input byte per beat, up to two decoded bytes queued per beat.
// Decoded bytes are written into the registered result queue and presented on out_valid from its head.
// Throughput: one input beat per cycle while each yields at most one byte and out_ready is
// high; a beat that yields two bytes fills the 4-entry result queue faster than it drains.
// in_ready is high while the result queue has room for two bytes.
// Reset (rst, synchronous) returns to plain text mode and empties the result queue.
module c_escape_sequence_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       is_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_final
);

  cesd_pkg::mode_t mode, mode_next;
  logic [7:0]      accum, accum_next;
  logic [1:0]      octal_digits, octal_digits_next;

  cesd_pkg::result_t                  queue [cesd_pkg::RESULT_DEPTH];
  logic [cesd_pkg::PTR_W-1:0]         wr_ptr, rd_ptr;
  logic [cesd_pkg::CNT_W-1:0]         count;

  logic       push, pop;
  logic [7:0] r0, r1, flush_byte, oct_shift;
  logic [1:0] n_res;
  logic       is_hex, is_oct;
  logic [3:0] hex_val;

  assign in_ready  = (count <= cesd_pkg::CNT_W'(cesd_pkg::RESULT_DEPTH - 2));
  assign push      = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_byte  = queue[rd_ptr].data;
  assign out_final = queue[rd_ptr].last;

  always_comb begin
    is_oct  = (ch >= cesd_pkg::CH_0) && (ch <= cesd_pkg::CH_7);
    is_hex  = ((ch >= cesd_pkg::CH_0) && (ch <= cesd_pkg::CH_9)) ||
              ((ch >= cesd_pkg::CH_LA) && (ch <= cesd_pkg::CH_LF)) ||
              ((ch >= cesd_pkg::CH_UA) && (ch <= cesd_pkg::CH_UF));
    // letters a-f / A-F have low nibble 1..6
    hex_val = (ch <= cesd_pkg::CH_9) ? ch[3:0] : ch[3:0] + 4'd9;
    oct_shift = {accum[4:0], ch[2:0]};
  end

  always_comb begin
    mode_next         = mode;
    accum_next        = accum;
    octal_digits_next = octal_digits;
    r0    = ch;
    r1    = ch;
    n_res = 2'd0;
    case (mode)
      cesd_pkg::MODE_ESC: begin
        if (ch == cesd_pkg::CH_X) begin
          mode_next = cesd_pkg::MODE_HEXSTART;
        end else if (is_oct) begin
          accum_next        = {5'd0, ch[2:0]};
          octal_digits_next = 2'd1;
          mode_next         = cesd_pkg::MODE_OCT;
        end else begin
          r0        = cesd_pkg::escape_code(ch);
          n_res     = 2'd1;
          mode_next = cesd_pkg::MODE_TEXT;
        end
      end
      cesd_pkg::MODE_HEXSTART: begin
        if (is_hex) begin
          accum_next = {4'd0, hex_val};
          mode_next  = cesd_pkg::MODE_HEX;
        end else begin
          r0    = cesd_pkg::CH_X;
          n_res = 2'd1;
          if (ch == cesd_pkg::CH_BSLASH) begin
            mode_next = cesd_pkg::MODE_ESC;
          end else begin
            n_res     = 2'd2;
            mode_next = cesd_pkg::MODE_TEXT;
          end
        end
      end
      cesd_pkg::MODE_HEX: begin
        if (is_hex) begin
          accum_next = {accum[3:0], hex_val};
        end else begin
          r0                = accum;
          n_res             = 2'd1;
          accum_next        = '0;
          octal_digits_next = '0;
          if (ch == cesd_pkg::CH_BSLASH) begin
            mode_next = cesd_pkg::MODE_ESC;
          end else begin
            n_res     = 2'd2;
            mode_next = cesd_pkg::MODE_TEXT;
          end
        end
      end
      cesd_pkg::MODE_OCT: begin
        if (is_oct) begin
          if (octal_digits == cesd_pkg::OCT_LAST_DIGIT) begin
            r0                = oct_shift;
            n_res             = 2'd1;
            accum_next        = '0;
            octal_digits_next = '0;
            mode_next         = cesd_pkg::MODE_TEXT;
          end else begin
            accum_next        = oct_shift;
            octal_digits_next = octal_digits + 2'd1;
          end
        end else begin
          r0                = accum;
          n_res             = 2'd1;
          accum_next        = '0;
          octal_digits_next = '0;
          if (ch == cesd_pkg::CH_BSLASH) begin
            mode_next = cesd_pkg::MODE_ESC;
          end else begin
            n_res     = 2'd2;
            mode_next = cesd_pkg::MODE_TEXT;
          end
        end
      end
      default: begin
        if (ch == cesd_pkg::CH_BSLASH) begin
          mode_next = cesd_pkg::MODE_ESC;
        end else begin
          n_res     = 2'd1;
          mode_next = cesd_pkg::MODE_TEXT;
        end
      end
    endcase

    // end of string: flush whatever escape is still open, then clear state
    case (mode_next)
      cesd_pkg::MODE_ESC:      flush_byte = 8'h00;
      cesd_pkg::MODE_HEXSTART: flush_byte = cesd_pkg::CH_X;
      default:                 flush_byte = accum_next;
    endcase
    if (is_final) begin
      if (mode_next != cesd_pkg::MODE_TEXT) begin
        if (n_res == 2'd0) begin
          r0    = flush_byte;
          n_res = 2'd1;
        end else begin
          r1    = flush_byte;
          n_res = 2'd2;
        end
      end
      mode_next         = cesd_pkg::MODE_TEXT;
      accum_next        = '0;
      octal_digits_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= cesd_pkg::MODE_TEXT;
      accum        <= '0;
      octal_digits <= '0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
    end else begin
      if (push) begin
        mode         <= mode_next;
        accum        <= accum_next;
        octal_digits <= octal_digits_next;
        wr_ptr       <= wr_ptr + cesd_pkg::PTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + cesd_pkg::PTR_W'(1);
      end
      count <= count + (push ? cesd_pkg::CNT_W'(n_res) : '0) - cesd_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && (n_res != 2'd0)) begin
      queue[wr_ptr] <= '{data: r0, last: is_final && (n_res == 2'd1)};
    end
    if (push && (n_res == 2'd2)) begin
      queue[wr_ptr + cesd_pkg::PTR_W'(1)] <= '{data: r1, last: is_final};
    end
  end

endmodule
